[sv/segment_mean_color_unit_defines.svh]
// ----------------------------------------------------------------------------
// segment mean color unit: assertion macros
// shared concurrent assertion forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef SEGMENT_MEAN_COLOR_UNIT_DEFINES_SVH
`define SEGMENT_MEAN_COLOR_UNIT_DEFINES_SVH

// condition on one edge implies consequence on the same edge
`define SMC_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition on one edge implies consequence on the next edge
`define SMC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition never holds
`define SMC_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[sv/smc_pkg.sv]
// ----------------------------------------------------------------------------
// smc_pkg
// types and constants shared by the segment mean color unit
// ----------------------------------------------------------------------------
package smc_pkg;

   localparam int LABEL_W                 = 12;
   localparam int CHAN_W                  = 8;
   localparam int SUM_W                   = 28;
   localparam int COUNT_W                 = 21;
   localparam int SEGMENT_ENTRIES_DEFAULT = 4096;
   localparam int PIXEL_LIMIT             = 1048576;
   localparam int LANES                   = 3;

   typedef enum logic [1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_READ       = 2'd1,
      OP_CLEAR      = 2'd2
   } smc_op_type;

   typedef struct packed {
      smc_op_type          op;
      logic [LABEL_W-1:0]  label;
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green;
      logic [CHAN_W-1:0]   blue;
   } smc_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mean_red;
      logic [CHAN_W-1:0] mean_green;
      logic [CHAN_W-1:0] mean_blue;
      logic              empty_res;
   } smc_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]   red_sum;
      logic [SUM_W-1:0]   green_sum;
      logic [SUM_W-1:0]   blue_sum;
      logic [COUNT_W-1:0] count;
   } smc_entry_type;

endpackage

[sv/smc_store.sv]
// ----------------------------------------------------------------------------
// smc_store
// per-segment sums and counts, one write and one registered read per cycle,
// swept to zero after reset
// ----------------------------------------------------------------------------
module smc_store
   import smc_pkg::*;
#(
   parameter int ENTRIES = SEGMENT_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   output logic                       clear_busy,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output smc_entry_type              rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  smc_entry_type              wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   smc_entry_type      mem [ENTRIES];
   smc_entry_type      rd_data_ff;
   logic               clr_busy_ff;
   logic               clr_busy_in;
   logic [IDX_W-1:0]   clr_addr_ff;
   logic [IDX_W-1:0]   clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == IDX_W'(ENTRIES - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // the sweep owns the write port until every entry is zero
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign clear_busy = clr_busy_ff;
   assign rd_data    = rd_data_ff;

endmodule

[sv/smc_divider.sv]
// ----------------------------------------------------------------------------
// smc_divider
// bit-serial restoring divider, one quotient bit per cycle, low byte out
// ----------------------------------------------------------------------------
`include "segment_mean_color_unit_defines.svh"

module smc_divider
   import smc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               busy,
   output logic [CHAN_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic               busy_ff;
   logic               busy_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic [SUM_W-1:0]   work_ff;
   logic [SUM_W-1:0]   work_in;
   logic [COUNT_W-1:0] rem_ff;
   logic [COUNT_W-1:0] rem_in;
   logic [COUNT_W-1:0] divisor_ff;
   logic [COUNT_W-1:0] divisor_in;
   logic [COUNT_W:0]   partial;
   logic [COUNT_W:0]   diff;
   logic               fits;

   // dividend shifts out at the top while quotient bits shift in at the bottom
   assign partial = {rem_ff, work_ff[SUM_W-1]};
   assign diff    = partial - {1'b0, divisor_ff};
   assign fits    = partial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(SUM_W - 1);
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[SUM_W-2:0], fits};
         rem_in  = fits ? diff[COUNT_W-1:0] : partial[COUNT_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff    <= step_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = work_ff[CHAN_W-1:0];

   `SMC_ASSERT_NEVER(a_start_while_busy, clock, reset, start && busy_ff, "divider restarted while busy")
   `SMC_ASSERT_IMPLIES(a_divisor_nonzero, clock, reset, start, divisor != '0, "divide by zero started")
   `SMC_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset, busy_ff, rem_ff < divisor_ff, "partial remainder not reduced")

endmodule

[sv/segment_mean_color_unit.sv]
// ----------------------------------------------------------------------------
// segment_mean_color_unit
// per-segment mean color: accumulate pixels, read channel means, clear entries
// ----------------------------------------------------------------------------
// After reset the store is swept to zero, one entry per cycle, so no request
// is taken until the sweep is done. An accumulate or clear is a store read,
// then a write back. A read is the store read, at whose end the dividers are
// loaded, then the three bit-serial dividers that run side by side, one
// quotient bit per cycle over the 28-bit sums, then a load of the result
// register. A read of an empty entry skips the dividers and goes from the
// store read on to the result register. The result register lets the next
// request be taken while a result is still waiting on rsp_ready; a later
// read holds its quotient until that register is free.
`include "segment_mean_color_unit_defines.svh"

module segment_mean_color_unit
   import smc_pkg::*;
#(
   parameter int SEGMENT_ENTRIES = SEGMENT_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  smc_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smc_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SEGMENT_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   smc_req_type        req_ff;
   smc_req_type        req_in;
   logic               in_range_ff;
   logic               in_range_in;
   logic               empty_ff;
   logic               empty_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   smc_rsp_type        rsp_data_ff;
   smc_rsp_type        rsp_data_in;

   logic               clear_busy;
   smc_entry_type      entry_rd;
   smc_entry_type      wr_data;
   logic               wr_en;
   logic               div_start;
   logic [LANES-1:0]   div_busy;
   logic [SUM_W-1:0]   div_dividend [LANES];
   logic [CHAN_W-1:0]  div_quotient [LANES];
   logic               accept;
   logic               rsp_free;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   smc_store #(
      .ENTRIES (SEGMENT_ENTRIES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .rd_addr    (IDX_W'(req_data.label)),
      .rd_data    (entry_rd),
      .wr_en      (wr_en),
      .wr_addr    (IDX_W'(req_ff.label)),
      .wr_data    (wr_data)
   );

   assign div_dividend[0] = entry_rd.red_sum;
   assign div_dividend[1] = entry_rd.green_sum;
   assign div_dividend[2] = entry_rd.blue_sum;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      smc_divider u_divider (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (div_dividend[i]),
         .divisor  (entry_rd.count),
         .busy     (div_busy[i]),
         .quotient (div_quotient[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      in_range_in  = in_range_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_data      = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               in_range_in = 32'(req_data.label) < 32'(SEGMENT_ENTRIES);
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (req_ff.op)
               OP_ACCUMULATE: begin
                  // full entries stay as they are
                  wr_en = in_range_ff && (32'(entry_rd.count) < 32'(PIXEL_LIMIT));
                  wr_data.red_sum   = entry_rd.red_sum + SUM_W'(req_ff.red);
                  wr_data.green_sum = entry_rd.green_sum + SUM_W'(req_ff.green);
                  wr_data.blue_sum  = entry_rd.blue_sum + SUM_W'(req_ff.blue);
                  wr_data.count     = entry_rd.count + 1'b1;
               end
               OP_READ: begin
                  empty_in  = !in_range_ff || (entry_rd.count == '0);
                  div_start = !empty_in;
                  state_in  = ST_DIVIDE;
               end
               OP_CLEAR: begin
                  wr_en = in_range_ff;
               end
               default: begin
               end
            endcase
         end
         ST_DIVIDE: begin
            if (!div_busy[0] && rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.mean_red   = empty_ff ? '0 : div_quotient[0];
               rsp_data_in.mean_green = empty_ff ? '0 : div_quotient[1];
               rsp_data_in.mean_blue  = empty_ff ? '0 : div_quotient[2];
               rsp_data_in.empty_res  = empty_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      in_range_ff <= in_range_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SMC_ASSERT_IMPLIES(a_lanes_in_step, clock, reset, 1'b1, (div_busy == '0) || (div_busy == '1), "divider lanes out of step")
   `SMC_ASSERT_NEVER(a_write_in_sweep, clock, reset, wr_en && clear_busy, "store write during clearing pass")
   `SMC_ASSERT_IMPLIES(a_rsp_from_divide, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DIVIDE), "result loaded outside divide state")
   `SMC_ASSERT_NEXT(a_start_busy, clock, reset, div_start, div_busy[0] && (state_ff == ST_DIVIDE), "divide start lost")

endmodule

[tb/segment_mean_color_unit_test.sv]
// ----------------------------------------------------------------------------
// segment_mean_color_unit_test
// drives accumulate, read, clear and unused-op transactions into the unit,
// keeps its own copy of the per-segment sums and counts, and checks every
// returned mean against it in order, under random idling and back-pressure
// ----------------------------------------------------------------------------
module segment_mean_color_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smc_pkg::*;

   localparam smc_op_type OP_UNUSED = smc_op_type'(2'd3);
   localparam int POOL_SIZE       = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 40;
   localparam int STALL_LIMIT     = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   smc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   smc_rsp_type rsp_data;

   // predicted contents of the segment store
   logic [SUM_W-1:0]   red_total   [SEGMENT_ENTRIES_DEFAULT] = '{default: '0};
   logic [SUM_W-1:0]   green_total [SEGMENT_ENTRIES_DEFAULT] = '{default: '0};
   logic [SUM_W-1:0]   blue_total  [SEGMENT_ENTRIES_DEFAULT] = '{default: '0};
   logic [COUNT_W-1:0] pixel_count [SEGMENT_ENTRIES_DEFAULT] = '{default: '0};

   smc_rsp_type expected_means[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          hold_off_pending = 1'b0;

   // segments in use: label and base color of each
   smc_req_type segment_pool [POOL_SIZE];

   segment_mean_color_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic smc_req_type make_request(input smc_op_type op,
                                                input int unsigned label,
                                                input int unsigned red,
                                                input int unsigned green,
                                                input int unsigned blue);
      smc_req_type item;
      item.op    = op;
      item.label = LABEL_W'(label);
      item.red   = CHAN_W'(red);
      item.green = CHAN_W'(green);
      item.blue  = CHAN_W'(blue);
      return item;
   endfunction

   // update the predicted store for one accepted transaction
   task automatic apply_request(input smc_req_type item);
      smc_rsp_type mean;
      int unsigned entry;
      entry = item.label;
      case (item.op)
         OP_ACCUMULATE: begin
            if (entry < SEGMENT_ENTRIES_DEFAULT && pixel_count[entry] < PIXEL_LIMIT) begin
               red_total[entry]   = red_total[entry] + item.red;
               green_total[entry] = green_total[entry] + item.green;
               blue_total[entry]  = blue_total[entry] + item.blue;
               pixel_count[entry] = pixel_count[entry] + 1'b1;
            end
         end
         OP_READ: begin
            mean = '0;
            if (entry >= SEGMENT_ENTRIES_DEFAULT || pixel_count[entry] == 0) begin
               mean.empty_res = 1'b1;
            end else begin
               mean.mean_red   = CHAN_W'(red_total[entry] / pixel_count[entry]);
               mean.mean_green = CHAN_W'(green_total[entry] / pixel_count[entry]);
               mean.mean_blue  = CHAN_W'(blue_total[entry] / pixel_count[entry]);
            end
            expected_means = {expected_means, mean};
         end
         OP_CLEAR: begin
            if (entry < SEGMENT_ENTRIES_DEFAULT) begin
               red_total[entry]   = '0;
               green_total[entry] = '0;
               blue_total[entry]  = '0;
               pixel_count[entry] = '0;
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_result(input smc_rsp_type got);
      smc_rsp_type want;
      if (expected_means.size() == 0) begin
         report_error($sformatf("result %h arrived with no read pending", got));
         return;
      end
      want = expected_means.pop_front();
      if (got.mean_red !== want.mean_red)
         report_error($sformatf("mean_red got %0d expected %0d", got.mean_red, want.mean_red));
      if (got.mean_green !== want.mean_green)
         report_error($sformatf("mean_green got %0d expected %0d",
                                got.mean_green, want.mean_green));
      if (got.mean_blue !== want.mean_blue)
         report_error($sformatf("mean_blue got %0d expected %0d",
                                got.mean_blue, want.mean_blue));
      if (got.empty_res !== want.empty_res)
         report_error($sformatf("empty_res got %0b expected %0b",
                                got.empty_res, want.empty_res));
   endtask

   // results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (req_valid && req_ready)
            apply_request(req_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= !(recv_idle_on && $urandom_range(99) < 29);
      end
   end

   // valid is only lowered in a gap, so it never toggles within one step
   task automatic send_request(input smc_req_type item);
      while (send_idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_means.size() != 0);
   endtask

   function automatic logic [CHAN_W-1:0] near_color(input logic [CHAN_W-1:0] base);
      int value;
      value = int'(base) + int'($urandom_range(40)) - 20;
      if (value < 0)
         value = 0;
      if (value > 255)
         value = 255;
      return CHAN_W'(value);
   endfunction

   function automatic void reseed_segment(input int slot);
      segment_pool[slot] = make_request(OP_ACCUMULATE, $urandom_range(4095),
                                        $urandom_range(255), $urandom_range(255),
                                        $urandom_range(255));
   endfunction

   // mostly pixels of a few live segments, with reads, clears and some noise
   function automatic smc_req_type random_request();
      smc_req_type item;
      int          slot;
      int          pick;
      slot = $urandom_range(POOL_SIZE - 1);
      pick = $urandom_range(99);
      item = segment_pool[slot];
      if (pick < 55) begin
         item.op    = OP_ACCUMULATE;
         item.red   = near_color(segment_pool[slot].red);
         item.green = near_color(segment_pool[slot].green);
         item.blue  = near_color(segment_pool[slot].blue);
      end else if (pick < 78) begin
         item.op = OP_READ;
      end else if (pick < 83) begin
         item.op = OP_CLEAR;
         reseed_segment(slot);
      end else if (pick < 86) begin
         item = make_request(OP_UNUSED, $urandom_range(4095), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
      end else if (pick < 93) begin
         item = make_request(OP_READ, $urandom_range(4095), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
      end else begin
         item = make_request(OP_ACCUMULATE, $urandom_range(4095), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
      end
      return item;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic test_directed_cases();
      // fresh store reads as empty at both ends of the label range
      send_request(make_request(OP_READ, 0, 255, 255, 255));
      send_request(make_request(OP_READ, 4095, 0, 0, 0));
      send_request(make_request(OP_ACCUMULATE, 0, 255, 255, 255));
      send_request(make_request(OP_ACCUMULATE, 0, 0, 0, 0));
      send_request(make_request(OP_READ, 0, 0, 0, 0));
      // truncating division: 256/3, 257/3, 258/3
      send_request(make_request(OP_ACCUMULATE, 4095, 255, 0, 170));
      send_request(make_request(OP_ACCUMULATE, 4095, 0, 255, 85));
      send_request(make_request(OP_ACCUMULATE, 4095, 1, 2, 3));
      send_request(make_request(OP_READ, 4095, 0, 0, 0));
      // unused op must leave the entry alone
      send_request(make_request(OP_UNUSED, 4095, 255, 255, 255));
      send_request(make_request(OP_READ, 4095, 0, 0, 0));
      send_request(make_request(OP_CLEAR, 0, 255, 255, 255));
      send_request(make_request(OP_READ, 0, 0, 0, 0));
      // cleared entry is reused from zero
      send_request(make_request(OP_ACCUMULATE, 0, 200, 100, 50));
      send_request(make_request(OP_READ, 0, 0, 0, 0));
      send_request(make_request(OP_CLEAR, 4095, 0, 0, 0));
      send_request(make_request(OP_READ, 4095, 0, 0, 0));
      send_request(make_request(OP_CLEAR, 12'hAAA, 0, 0, 0));
      send_request(make_request(OP_ACCUMULATE, 12'h555, 170, 85, 255));
      send_request(make_request(OP_READ, 12'h555, 0, 0, 0));
      send_request(make_request(OP_READ, 12'hAAA, 0, 0, 0));
   endtask

   task automatic test_random_segments();
      for (int slot = 0; slot < POOL_SIZE; slot++)
         reseed_segment(slot);
      send_random(700);
   endtask

   task automatic test_back_to_back();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      send_random(150);
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // a result waits behind a stalled receiver, then the next read stalls the input too
   task automatic test_result_backpressure();
      smc_req_type item;
      hold_off_pending = 1'b1;
      for (int i = 0; i < 40; i++) begin
         item = random_request();
         if (i % 4 == 0)
            item.op = OP_READ;
         send_request(item);
      end
   endtask

   task automatic test_pause_until_drained();
      wait_for_results();
      send_random(135);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_segments();
      test_back_to_back();
      test_result_backpressure();
      test_pause_until_drained();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_means.size() != 0)
         report_error($sformatf("%0d reads never answered", expected_means.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
